// File: rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// shared types and constants of the waypoint seek steering block
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_APPEND  = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_RESTART = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  // arrival radius, 140 units in q8
  localparam logic [31:0] NEAR_Q8    = 32'd35840;
  localparam logic [63:0] NEAR_SQ_Q8 = 64'd1284505600;

  localparam logic [23:0] MAX_SPEED_RST = 24'd153600;

  // quotient bits of the speed division, q <= max_speed + 1
  localparam int unsigned QUOT_W = 26;

  localparam logic signed [34:0] I32_MAX = 35'sd2147483647;
  localparam logic signed [34:0] I32_MIN = -35'sd2147483648;

endpackage

`default_nettype wire

// File: rtl/waypoint_seek_steering_top.sv
// ----------------------------------------------------------------------------
// waypoint_seek_steering_top
// seek steering toward a ring of planar waypoints, one shared multiplier,
// a bit-pair square root and a restoring divider under one sequencer
// ----------------------------------------------------------------------------
// sequence: append, clear and restart go from idle to done and load their
//   result from there; a step runs fetch, difference and magnitude, the
//   squares, the square root iterations, then per axis a multiply, a divide
//   setup, the divide iterations and a saturate, and then loads the result,
//   plus any wait on the output side
// throughput: one item at a time, the next item is taken once the sequencer
//   is back in idle, while the last result may still wait on the output
// reset: asynchronous active low; clears count, index and max_speed to 600.0
`default_nettype none

module waypoint_seek_steering_top import wss_pkg::*; #(
  parameter int unsigned MAX_WAYPOINTS = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [23:0]  cfg_data_i,     // max_speed
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // pos_x, pos_y, pos_z, prev_vx, prev_vy, prev_vz
  input  wire logic [191:0] s_axis_tdata_i,
  input  wire logic [1:0]   s_axis_tuser_i, // opcode
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // steer_x, steer_y, steer_z, waypoint_index, 2 zero bits
  output logic [103:0]      m_axis_tdata_o,
  output logic [1:0]        m_axis_tuser_o  // status
);

  localparam int unsigned IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_NORM, S_SQ, S_SQRT, S_MULK, S_DIVI, S_DIV, S_FIN, S_DONE
  } state_e;

  state_e state_q;

  logic [23:0]   speed_q;
  logic [CW-1:0] count_q;
  logic [IW-1:0] idx_q;

  logic [63:0] mem_q [MAX_WAYPOINTS];
  logic [63:0] rd_q;

  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [31:0] pv_q [3];
  logic signed [32:0] d_q [3];
  logic [31:0]  a_q [3];
  logic [2:0]   neg_q;
  logic         small_q;
  logic [63:0]  prod_q, sum_q, xs_q;
  logic [34:0]  rem_q;
  logic [31:0]  root_q, n_q;
  logic [33:0]  drem_q;
  logic [QUOT_W-1:0] nlo_q, quo_q;
  logic [4:0]   cnt_q;
  logic [1:0]   k_q;
  logic signed [31:0] res_q [3];
  logic [1:0]   stat_q;

  logic [31:0]  out_x_q, out_y_q, out_z_q;
  logic [5:0]   out_idx_q;
  logic [1:0]   out_stat_q;
  logic         m_valid_q;

  logic in_xfer;
  logic out_load;
  logic [IW-1:0] tgt;
  logic [CW-1:0] idx_nx;
  logic [1:0]  msel;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] sum_d;
  logic [34:0] sq_rem, sq_trial;
  logic [56:0] num;
  logic [33:0] dv_rem;
  logic [33:0] dv_div;
  logic signed [33:0] want;
  logic signed [34:0] diff;
  logic [31:0] mag_o [3];
  logic signed [32:0] dh [3];
  logic [31:0] mag_h [3];
  logic big;
  logic [IW+5:0] idx_ext;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_load        = (state_q == S_DONE) && (!m_valid_q || m_axis_tready_i);

  assign tgt    = (CW'(idx_q) < count_q) ? idx_q : '0;
  assign idx_nx = CW'(idx_q) + CW'(1);

  // shared multiplier
  assign msel  = (state_q == S_SQ) ? cnt_q[1:0] : k_q;
  always_comb begin
    case (msel)
      2'd0: mul_a = a_q[0];
      2'd1: mul_a = a_q[1];
      default: mul_a = a_q[2];
    endcase
  end
  assign mul_b = (state_q == S_SQ) ? mul_a : {8'd0, speed_q};
  assign mul_p = mul_a * mul_b;
  assign sum_d = sum_q + prod_q;

  // magnitudes, halved when any exceeds 31 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_o[i] = d_q[i][32] ? 32'(-d_q[i]) : d_q[i][31:0];
      dh[i]    = d_q[i] >>> 1;
    end
    big = mag_o[0][31] | mag_o[1][31] | mag_o[2][31];
    for (int i = 0; i < 3; i++) begin
      mag_h[i] = big ? (dh[i][32] ? 32'(-dh[i]) : dh[i][31:0]) : mag_o[i];
    end
  end

  assign sq_rem   = {rem_q[32:0], xs_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};

  assign num    = {prod_q[55:0], 1'b0} + 57'(n_q);
  assign dv_div = {1'b0, n_q, 1'b0};
  assign dv_rem = {drem_q[32:0], nlo_q[QUOT_W-1]};

  assign want = neg_q[k_q] ? -$signed({8'd0, quo_q}) : $signed({8'd0, quo_q});
  assign diff = ((n_q == '0) ? 35'sd0 : 35'(want)) - 35'(pv_q[k_q]);

  assign idx_ext = {6'd0, idx_q};

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tuser_i == OP_APPEND && CW'(MAX_WAYPOINTS) != count_q) begin
      mem_q[count_q[IW-1:0]] <= s_axis_tdata_i[63:0];
    end
    if (in_xfer) begin
      rd_q <= mem_q[tgt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      speed_q   <= MAX_SPEED_RST;
      count_q   <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        speed_q <= cfg_data_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            for (int i = 0; i < 3; i++) res_q[i] <= '0;
            px_q  <= s_axis_tdata_i[31:0];
            py_q  <= s_axis_tdata_i[63:32];
            pz_q  <= s_axis_tdata_i[95:64];
            pv_q[0] <= s_axis_tdata_i[127:96];
            pv_q[1] <= s_axis_tdata_i[159:128];
            pv_q[2] <= s_axis_tdata_i[191:160];
            case (s_axis_tuser_i)
              OP_APPEND: begin
                state_q <= S_DONE;
                if (count_q == CW'(MAX_WAYPOINTS)) begin
                  stat_q <= ST_FULL;
                end else begin
                  stat_q  <= ST_OK;
                  count_q <= count_q + CW'(1);
                end
              end
              OP_CLEAR: begin
                stat_q  <= ST_OK;
                state_q <= S_DONE;
                count_q <= '0;
                idx_q   <= '0;
              end
              OP_RESTART: begin
                stat_q  <= ST_OK;
                state_q <= S_DONE;
                idx_q   <= '0;
              end
              default: begin
                if (count_q == '0) begin
                  stat_q  <= ST_NONE;
                  state_q <= S_DONE;
                end else begin
                  stat_q  <= ST_OK;
                  idx_q   <= tgt;
                  state_q <= S_DIFF;
                end
              end
            endcase
          end
        end
        S_DIFF: begin
          d_q[0]  <= 33'($signed(rd_q[31:0])) - 33'(px_q);
          d_q[1]  <= 33'($signed(rd_q[63:32])) - 33'(py_q);
          d_q[2]  <= -33'(pz_q);
          state_q <= S_NORM;
        end
        S_NORM: begin
          for (int i = 0; i < 3; i++) begin
            a_q[i]   <= mag_h[i];
            neg_q[i] <= d_q[i][32];
          end
          small_q <= (mag_o[0] < NEAR_Q8) && (mag_o[1] < NEAR_Q8) && (mag_o[2] < NEAR_Q8);
          sum_q   <= '0;
          prod_q  <= '0;
          cnt_q   <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          prod_q <= mul_p;
          sum_q  <= sum_d;
          if (cnt_q == 5'd3) begin
            xs_q   <= sum_d;
            rem_q  <= '0;
            root_q <= '0;
            cnt_q  <= '0;
            if (small_q && sum_d < NEAR_SQ_Q8) begin
              idx_q <= (idx_nx >= count_q) ? '0 : idx_nx[IW-1:0];
            end
            state_q <= S_SQRT;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_SQRT: begin
          xs_q  <= {xs_q[61:0], 2'b00};
          cnt_q <= cnt_q + 5'd1;
          if (sq_rem >= sq_trial) begin
            rem_q  <= sq_rem - sq_trial;
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q  <= sq_rem;
            root_q <= {root_q[30:0], 1'b0};
          end
          if (cnt_q == 5'd31) begin
            k_q     <= '0;
            state_q <= S_MULK;
          end
        end
        S_MULK: begin
          n_q     <= root_q;
          prod_q  <= mul_p;
          state_q <= S_DIVI;
        end
        S_DIVI: begin
          drem_q  <= {3'd0, num[56:QUOT_W]};
          nlo_q   <= num[QUOT_W-1:0];
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          nlo_q <= {nlo_q[QUOT_W-2:0], 1'b0};
          cnt_q <= cnt_q + 5'd1;
          if (dv_rem >= dv_div) begin
            drem_q <= dv_rem - dv_div;
            quo_q  <= {quo_q[QUOT_W-2:0], 1'b1};
          end else begin
            drem_q <= dv_rem;
            quo_q  <= {quo_q[QUOT_W-2:0], 1'b0};
          end
          if (cnt_q == 5'(QUOT_W - 1)) state_q <= S_FIN;
        end
        S_FIN: begin
          if (diff > I32_MAX)      res_q[k_q] <= I32_MAX[31:0];
          else if (diff < I32_MIN) res_q[k_q] <= I32_MIN[31:0];
          else                     res_q[k_q] <= diff[31:0];
          k_q     <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
          state_q <= (k_q == 2'd2) ? S_DONE : S_MULK;
        end
        S_DONE: begin
          if (out_load) begin
            out_x_q    <= res_q[0];
            out_y_q    <= res_q[1];
            out_z_q    <= res_q[2];
            out_idx_q  <= idx_ext[5:0];
            out_stat_q <= stat_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_idx_q, out_z_q, out_y_q, out_x_q};
  assign m_axis_tuser_o  = out_stat_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WAYPOINTS))
    else $error("waypoint count beyond store");

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (CW'(idx_q) < count_q || idx_q == '0))
    else $error("index outside ring");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |=> (m_valid_q && $stable(out_x_q) && $stable(out_stat_q)))
    else $error("pending result changed");

  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |=> !s_axis_tready_o)
    else $error("input taken mid step");

endmodule

`default_nettype wire
